// File: sv/interval_timer_group_oneshot_square_unit_macros.svh
// assertion helpers shared by the timer files
`ifndef INTERVAL_TIMER_GROUP_ONESHOT_SQUARE_UNIT_MACROS_SVH
`define INTERVAL_TIMER_GROUP_ONESHOT_SQUARE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITGOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ITGOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/itgos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itgos_pkg;

    localparam int NUM_GROUPS = 3;
    localparam int COUNT_BITS = 16;
    localparam int GROUP_CHANS = 3;
    localparam int NUM_CHANS = NUM_GROUPS * GROUP_CHANS;
    localparam int CHAN_SLOTS = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] OFF_CTRL = 2'd3;

    localparam logic [1:0] LATCH_LOW = 2'd1;
    localparam logic [1:0] LATCH_HIGH = 2'd2;
    localparam logic [1:0] LATCH_BOTH = 2'd3;

    localparam logic [2:0] MODE_ONESHOT = 3'd1;
    localparam logic [2:0] MODE_SQUARE = 3'd3;

    // per-channel command decoded from one item
    typedef struct packed {
        logic       cnt_wr;
        logic       ctl_wr;
        logic       tick;
        logic       gate;
        logic [7:0] data;
    } t_chan_cmd;

endpackage

`default_nettype wire

// File: sv/interval_timer_group_oneshot_square_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "interval_timer_group_oneshot_square_unit_macros.svh"

// Nine interval counter channels in three groups. Each item (a register write
// or a clock tick) is captured in an input register and applied to all
// channels once no result waits untaken; the channel state registers then
// present the nine output levels as the result, one result per item. One item
// is taken every cycle while results are taken; a result that is not yet
// taken holds the channels and the input register holds one more item, after
// which input ready drops until the result is taken.
module interval_timer_group_oneshot_square_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_op,
    input  wire logic [1:0]             i_group_select,
    input  wire logic [1:0]             i_reg_offset,
    input  wire logic [7:0]             i_write_data,
    input  wire logic [8:0]             i_clock_enables,
    input  wire logic [8:0]             i_gate_levels,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [8:0]                  o_out_levels
);
    import itgos_pkg::*;

    logic       r_in_valid;
    logic       r_out_valid;
    logic       r_op;
    logic [1:0] r_group_select;
    logic [1:0] r_reg_offset;
    logic [7:0] r_write_data;
    logic [8:0] r_clock_enables;
    logic [8:0] r_gate_levels;
    logic       w_adv;
    logic [CHAN_SLOTS-1:0] w_levels;

    assign w_adv = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op <= i_op;
            r_group_select <= i_group_select;
            r_reg_offset <= i_reg_offset;
            r_write_data <= i_write_data;
            r_clock_enables <= i_clock_enables;
            r_gate_levels <= i_gate_levels;
        end
    end

    for (genvar gi = 0; gi < CHAN_SLOTS; gi++) begin : g_chan
        if (gi < NUM_CHANS) begin : g_live
            localparam int G = gi / GROUP_CHANS;
            localparam int C = gi % GROUP_CHANS;
            t_chan_cmd w_cmd;

            always_comb begin
                w_cmd.cnt_wr = (r_op == OP_WRITE) && (r_group_select == 2'(G))
                    && (r_reg_offset == 2'(C));
                w_cmd.ctl_wr = (r_op == OP_WRITE) && (r_group_select == 2'(G))
                    && (r_reg_offset == OFF_CTRL) && (r_write_data[7:6] == 2'(C));
                w_cmd.tick = (r_op == OP_TICK) && r_clock_enables[gi];
                w_cmd.gate = r_gate_levels[gi];
                w_cmd.data = r_write_data;
            end

            itgos_chan u_chan (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_upd   (w_adv),
                .i_cmd   (w_cmd),
                .o_level (w_levels[gi])
            );
        end else begin : g_absent
            assign w_levels[gi] = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_levels = w_levels;

    `ITGOS_ASSERT_NEXT(a_in_kept, r_in_valid && !w_adv, r_in_valid, "pending item dropped")
    `ITGOS_ASSERT_NOW(a_out_from_in, $rose(r_out_valid), $past(r_in_valid), "result without an item")
    `ITGOS_ASSERT_NEXT(a_levels_held, r_out_valid && !i_out_ready, $stable(w_levels), "channel levels moved under a waiting result")

endmodule

`default_nettype wire

// File: sv/itgos_chan.sv
`timescale 1ns / 1ps
`default_nettype none
`include "interval_timer_group_oneshot_square_unit_macros.svh"

module itgos_chan (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_upd,
    input  wire itgos_pkg::t_chan_cmd i_cmd,
    output logic                     o_level
);
    import itgos_pkg::*;

    logic [COUNT_BITS-1:0] r_reload, n_reload;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic                  r_hold, n_hold;
    logic [1:0]            r_latch, n_latch;
    logic [2:0]            r_mode, n_mode;
    logic                  r_toggle, n_toggle;
    logic                  r_out, n_out;
    logic                  r_gate, n_gate;

    logic [15:0]           w_full;
    logic [COUNT_BITS-1:0] w_dec;
    logic [COUNT_BITS-1:0] w_sq;

    assign w_full = 16'(r_reload);
    assign w_dec = r_rem - COUNT_BITS'(1);
    // square wave counts by two: low bit forced clear
    assign w_sq = {w_dec[COUNT_BITS-1:1], 1'b0};

    always_comb begin
        n_reload = r_reload;
        n_rem = r_rem;
        n_hold = r_hold;
        n_latch = r_latch;
        n_mode = r_mode;
        n_toggle = r_toggle;
        n_out = r_out;
        n_gate = r_gate;
        if (i_cmd.cnt_wr) begin
            case (r_latch)
                LATCH_LOW: begin
                    n_reload = COUNT_BITS'(16'(i_cmd.data));
                    n_hold = 1'b0;
                end
                LATCH_HIGH: begin
                    n_reload = COUNT_BITS'({i_cmd.data, 8'h00});
                    n_hold = 1'b0;
                end
                LATCH_BOTH: begin
                    if (!r_toggle) begin
                        n_reload = COUNT_BITS'({w_full[15:8], i_cmd.data});
                        n_toggle = 1'b1;
                    end else begin
                        n_reload = COUNT_BITS'({i_cmd.data, w_full[7:0]});
                        n_hold = 1'b0;
                        n_toggle = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            // release from hold starts the count at one
            if (r_hold && !n_hold) begin
                n_rem = COUNT_BITS'(1);
            end
        end else if (i_cmd.ctl_wr) begin
            n_hold = 1'b1;
            n_latch = i_cmd.data[5:4];
            n_mode = i_cmd.data[3:1];
            n_toggle = 1'b0;
            n_out = (i_cmd.data[3:1] == MODE_ONESHOT);
        end else if (i_cmd.tick) begin
            n_gate = i_cmd.gate;
            if (!r_hold) begin
                case (r_mode)
                    MODE_ONESHOT: begin
                        if (!r_gate && i_cmd.gate) begin
                            n_out = 1'b0;
                            n_rem = r_reload;
                        end else begin
                            n_rem = w_dec;
                            if (w_dec == '0) begin
                                n_out = 1'b1;
                            end
                        end
                    end
                    MODE_SQUARE: begin
                        if (w_sq == '0) begin
                            n_out = ~r_out;
                            n_rem = r_reload;
                        end else begin
                            n_rem = w_sq;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= '0;
            r_rem <= '0;
            r_hold <= 1'b1;
            r_latch <= '0;
            r_mode <= '0;
            r_toggle <= 1'b0;
            r_out <= 1'b0;
            r_gate <= 1'b0;
        end else if (i_upd) begin
            r_reload <= n_reload;
            r_rem <= n_rem;
            r_hold <= n_hold;
            r_latch <= n_latch;
            r_mode <= n_mode;
            r_toggle <= n_toggle;
            r_out <= n_out;
            r_gate <= n_gate;
        end
    end

    assign o_level = r_out;

    `ITGOS_ASSERT_NEXT(a_ctl_oneshot_out, i_upd && i_cmd.ctl_wr && i_cmd.data[3:1] == MODE_ONESHOT, o_level, "one-shot control word must raise output")
    `ITGOS_ASSERT_NEXT(a_held_tick_keeps, i_upd && i_cmd.tick && !i_cmd.cnt_wr && !i_cmd.ctl_wr && r_hold, $stable(r_rem) && $stable(r_out), "held channel changed on a tick")
    `ITGOS_ASSERT_NEXT(a_ctl_holds, i_upd && i_cmd.ctl_wr && !i_cmd.cnt_wr, r_hold && !r_toggle, "control word must hold channel")

endmodule

`default_nettype wire
